// ----- src/btmx_pkg.sv -----
// ----------------------------------------------------------------------------
// btmx_pkg: shared types for the binary trie max-xor block
// Operation modes, status codes, sequencer states and memory write enables.
// ----------------------------------------------------------------------------
package btmx_pkg;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_ABSENT = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_RSVD   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_WALK,
    ST_ALLOC_CLR,
    ST_ALLOC_LINK,
    ST_INC,
    ST_PRUNE_RD,
    ST_PRUNE_EX,
    ST_DONE
  } state_t;

  // write enables towards the node store
  typedef struct packed {
    logic link0;
    logic link1;
    logic count;
    logic stack;
    logic path;
  } mem_we_t;

  localparam int unsigned FIELD_BITS = 30;

endpackage

// ----- src/btmx_mem.sv -----
// ----------------------------------------------------------------------------
// btmx_mem: node store
// Child links, leaf counts, free stack and remove path; registered reads.
// The root's links live in flip-flops so they are cleared by reset.
// ----------------------------------------------------------------------------
module btmx_mem
  import btmx_pkg::*;
#(
  parameter int NODES      = 4096,
  parameter int KEY_BITS   = 30,
  parameter int COUNT_BITS = 16,
  localparam int IW        = $clog2(NODES),
  localparam int BW        = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mem_we_t               we,
  input  logic [IW-1:0]         node_raddr,
  input  logic [IW-1:0]         node_waddr,
  input  logic [IW-1:0]         link_wdata,
  input  logic [COUNT_BITS-1:0] count_wdata,
  input  logic [IW-1:0]         stk_raddr,
  input  logic [IW-1:0]         stk_waddr,
  input  logic [BW-1:0]         path_raddr,
  input  logic [BW-1:0]         path_waddr,
  input  logic [IW-1:0]         idx_wdata,
  output logic [IW-1:0]         link0_q,
  output logic [IW-1:0]         link1_q,
  output logic [COUNT_BITS-1:0] count_q,
  output logic [IW-1:0]         stk_q,
  output logic [IW-1:0]         path_q
);

  logic [IW-1:0]         link0_mem [NODES];
  logic [IW-1:0]         link1_mem [NODES];
  logic [COUNT_BITS-1:0] count_mem [NODES];
  logic [IW-1:0]         stk_mem   [NODES];
  logic [IW-1:0]         path_mem  [KEY_BITS];

  logic [IW-1:0] root0_r, root1_r, mem0_q, mem1_q;
  logic          root_rd_r;
  logic          root_wr;

  assign root_wr = (node_waddr == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root0_r <= '0;
      root1_r <= '0;
    end else begin
      if (we.link0 && root_wr) root0_r <= link_wdata;
      if (we.link1 && root_wr) root1_r <= link_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we.link0) link0_mem[node_waddr] <= link_wdata;
    if (we.link1) link1_mem[node_waddr] <= link_wdata;
    if (we.count) count_mem[node_waddr] <= count_wdata;
    if (we.stack) stk_mem[stk_waddr]    <= idx_wdata;
    if (we.path)  path_mem[path_waddr]  <= idx_wdata;
    mem0_q    <= link0_mem[node_raddr];
    mem1_q    <= link1_mem[node_raddr];
    count_q   <= count_mem[node_raddr];
    stk_q     <= stk_mem[stk_raddr];
    path_q    <= path_mem[path_raddr];
    root_rd_r <= (node_raddr == '0);
  end

  assign link0_q = root_rd_r ? root0_r : mem0_q;
  assign link1_q = root_rd_r ? root1_r : mem1_q;

endmodule

// ----- src/btmx_ctrl.sv -----
// ----------------------------------------------------------------------------
// btmx_ctrl: walk sequencer
// Steps one trie level at a time for insert, remove, prune and query.
// ----------------------------------------------------------------------------
module btmx_ctrl
  import btmx_pkg::*;
#(
  parameter int NODES      = 4096,
  parameter int KEY_BITS   = 30,
  parameter int COUNT_BITS = 16,
  localparam int IW        = $clog2(NODES),
  localparam int NW        = IW + 1,
  localparam int AW        = IW + 2,
  localparam int LW        = $clog2(KEY_BITS + 1),
  localparam int BW        = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  mode_t                 req_mode,
  input  logic [KEY_BITS-1:0]   req_key,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output logic [KEY_BITS-1:0]   rsp_result,
  output status_t               rsp_status,
  output mem_we_t               we,
  output logic [IW-1:0]         node_raddr,
  output logic [IW-1:0]         node_waddr,
  output logic [IW-1:0]         link_wdata,
  output logic [COUNT_BITS-1:0] count_wdata,
  output logic [IW-1:0]         stk_raddr,
  output logic [IW-1:0]         stk_waddr,
  output logic [BW-1:0]         path_raddr,
  output logic [BW-1:0]         path_waddr,
  output logic [IW-1:0]         idx_wdata,
  input  logic [IW-1:0]         link0_q,
  input  logic [IW-1:0]         link1_q,
  input  logic [COUNT_BITS-1:0] count_q,
  input  logic [IW-1:0]         stk_q,
  input  logic [IW-1:0]         path_q
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  state_t                state_r, state_nxt;
  mode_t                 mode_r, mode_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt, res_r, res_nxt;
  status_t               stat_r, stat_nxt;
  logic [IW-1:0]         cur_r, cur_nxt, new_r, new_nxt;
  logic [LW-1:0]         lvl_r, lvl_nxt;
  logic [NW-1:0]         next_unused_r, next_unused_nxt, free_top_r, free_top_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [KEY_BITS-1:0]   out_res_r, out_res_nxt;
  status_t               out_stat_r, out_stat_nxt;

  logic [KEY_BITS-1:0] walk_sh, prune_sh, bit_mask;
  logic                walk_bit, prune_bit, lvl_zero, no_room, no_kids;
  logic [IW-1:0]       child, other, alloc_idx;
  logic [AW-1:0]       avail;
  logic                accept, out_load;

  assign lvl_zero  = (lvl_r == '0);
  assign walk_sh   = key_r >> (lvl_r - LW'(1));
  assign walk_bit  = walk_sh[0];
  assign prune_sh  = key_r >> lvl_r;
  assign prune_bit = prune_sh[0];
  assign bit_mask  = KEY_BITS'(1) << (lvl_r - LW'(1));
  assign child     = walk_bit ? link1_q : link0_q;
  assign other     = walk_bit ? link0_q : link1_q;
  assign no_kids   = (link0_q == '0) && (link1_q == '0);
  assign avail     = AW'(free_top_r) + AW'(NODES) - AW'(next_unused_r);
  assign no_room   = AW'(lvl_r) > avail;
  assign alloc_idx = (free_top_r != '0) ? stk_q : next_unused_r[IW-1:0];

  assign req_ready = (state_r == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || rsp_ready);

  assign rsp_valid  = out_valid_r;
  assign rsp_result = out_res_r;
  assign rsp_status = out_stat_r;

  // fixed address wiring
  assign node_raddr = cur_r;
  assign stk_raddr  = IW'(free_top_r - NW'(1));
  assign stk_waddr  = free_top_r[IW-1:0];
  assign path_raddr = lvl_r[BW-1:0];
  assign path_waddr = BW'(lvl_r - LW'(1));
  assign idx_wdata  = cur_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (req_mode == MODE_NONE) state_nxt = ST_DONE;
          else                       state_nxt = ST_RD;
        end
      end
      ST_RD: state_nxt = ST_WALK;
      ST_WALK: begin
        case (mode_r)
          MODE_INSERT: begin
            if (!lvl_zero && child != '0) state_nxt = ST_RD;
            else if (no_room)             state_nxt = ST_DONE;
            else if (lvl_zero)            state_nxt = (count_q == COUNT_MAX) ? ST_DONE : ST_INC;
            else                          state_nxt = ST_ALLOC_CLR;
          end
          MODE_REMOVE: begin
            if (lvl_zero)          state_nxt = (count_q == COUNT_BITS'(1)) ? ST_PRUNE_RD
                                                                           : ST_DONE;
            else if (child == '0)  state_nxt = ST_DONE;
            else                   state_nxt = ST_RD;
          end
          default: begin
            if (lvl_zero || (other == '0 && child == '0)) state_nxt = ST_DONE;
            else                                          state_nxt = ST_RD;
          end
        endcase
      end
      ST_ALLOC_CLR:  state_nxt = ST_ALLOC_LINK;
      ST_ALLOC_LINK: state_nxt = (lvl_r == LW'(1)) ? ST_INC : ST_ALLOC_CLR;
      ST_INC:        state_nxt = ST_DONE;
      ST_PRUNE_RD:   state_nxt = ST_PRUNE_EX;
      ST_PRUNE_EX: begin
        if (!no_kids || lvl_r == LW'(KEY_BITS - 1)) state_nxt = ST_DONE;
        else                                       state_nxt = ST_PRUNE_RD;
      end
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    mode_nxt        = mode_r;
    key_nxt         = key_r;
    res_nxt         = res_r;
    stat_nxt        = stat_r;
    cur_nxt         = cur_r;
    new_nxt         = new_r;
    lvl_nxt         = lvl_r;
    cnt_nxt         = cnt_r;
    next_unused_nxt = next_unused_r;
    free_top_nxt    = free_top_r;
    out_res_nxt     = out_res_r;
    out_stat_nxt    = out_stat_r;
    out_valid_nxt   = out_valid_r && !rsp_ready;
    we              = '0;
    node_waddr      = cur_r;
    link_wdata      = '0;
    count_wdata     = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          mode_nxt = req_mode;
          key_nxt  = req_key;
          res_nxt  = '0;
          stat_nxt = STAT_OK;
          cur_nxt  = '0;
          lvl_nxt  = LW'(KEY_BITS);
        end
      end
      ST_WALK: begin
        cnt_nxt = count_q;
        case (mode_r)
          MODE_INSERT: begin
            if (!lvl_zero && child != '0) begin
              cur_nxt = child;
              lvl_nxt = lvl_r - LW'(1);
            end else if (no_room || (lvl_zero && count_q == COUNT_MAX)) begin
              stat_nxt = STAT_FULL;
            end
          end
          MODE_REMOVE: begin
            if (lvl_zero) begin
              if (count_q == '0) begin
                stat_nxt = STAT_ABSENT;
              end else begin
                we.count    = 1'b1;
                count_wdata = count_q - COUNT_BITS'(1);
              end
            end else if (child == '0) begin
              stat_nxt = STAT_ABSENT;
            end else begin
              we.path = 1'b1;
              cur_nxt = child;
              lvl_nxt = lvl_r - LW'(1);
            end
          end
          default: begin
            if (!lvl_zero) begin
              lvl_nxt = lvl_r - LW'(1);
              if (other != '0) begin
                res_nxt = res_r | bit_mask;
                cur_nxt = other;
              end else if (child != '0) begin
                cur_nxt = child;
              end
            end
          end
        endcase
      end
      ST_ALLOC_CLR: begin
        // fresh node: no children, zero count
        we.link0   = 1'b1;
        we.link1   = 1'b1;
        we.count   = 1'b1;
        node_waddr = alloc_idx;
        new_nxt    = alloc_idx;
        if (free_top_r != '0) free_top_nxt    = free_top_r - NW'(1);
        else                  next_unused_nxt = next_unused_r + NW'(1);
      end
      ST_ALLOC_LINK: begin
        we.link0   = !walk_bit;
        we.link1   = walk_bit;
        link_wdata = new_r;
        cur_nxt    = new_r;
        lvl_nxt    = lvl_r - LW'(1);
        cnt_nxt    = '0;
      end
      ST_INC: begin
        we.count    = 1'b1;
        count_wdata = cnt_r + COUNT_BITS'(1);
      end
      ST_PRUNE_EX: begin
        if (no_kids) begin
          if (free_top_r < NW'(NODES)) begin
            we.stack     = 1'b1;
            free_top_nxt = free_top_r + NW'(1);
          end
          we.link0   = !prune_bit;
          we.link1   = prune_bit;
          node_waddr = path_q;
          cur_nxt    = path_q;
          lvl_nxt    = lvl_r + LW'(1);
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          out_stat_nxt  = stat_r;
        end
      end
      default: ;
    endcase
    // a remove that reaches a single-copy leaf starts pruning from bit 0
    if (state_r == ST_WALK && mode_r == MODE_REMOVE && lvl_zero) lvl_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      next_unused_r <= NW'(1);
      free_top_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      next_unused_r <= next_unused_nxt;
      free_top_r    <= free_top_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    key_r      <= key_nxt;
    res_r      <= res_nxt;
    stat_r     <= stat_nxt;
    cur_r      <= cur_nxt;
    new_r      <= new_nxt;
    lvl_r      <= lvl_nxt;
    cnt_r      <= cnt_nxt;
    out_res_r  <= out_res_nxt;
    out_stat_r <= out_stat_nxt;
  end

`ifndef SYNTHESIS
  a_free_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_top_r <= NW'(NODES))
    else $error("free stack overflow");
  a_next_unused_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_unused_r <= NW'(NODES))
    else $error("pool pointer past end");
  a_full_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && stat_r == STAT_FULL) |-> mode_r == MODE_INSERT)
    else $error("full status on non-insert");
  a_res_only_query: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && res_r != '0) |-> mode_r == MODE_QUERY)
    else $error("xor result on non-query");
  a_prune_level: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PRUNE_EX) |-> lvl_r < LW'(KEY_BITS))
    else $error("prune walked past the root");
`endif

endmodule

// ----- src/binary_trie_max_xor.sv -----
// ----------------------------------------------------------------------------
// binary_trie_max_xor: multiset of keys in a binary trie with max-xor query
// Insert, remove and max-xor query over a node pool; one response per request.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_*: in_tuser carries the mode (0 insert, 1 remove,
//   2 query), in_tdata the key. Each request gives exactly one response on
//   out_*: out_tdata the xor result (queries only), out_tuser the status
//   (0 ok, 1 key absent on remove, 2 pool or count full on insert).
//   One request is handled at a time; in_tready is high only while idle.
//   Each trie level visited, the leaf included, takes a read step and a
//   walk step, followed by the response step; an insert builds each new
//   node in a clear step and a link step in place of a level read, then
//   updates the count; a remove adds a read step and a prune step per
//   pruned node. The next request is taken in the cycle after the
//   response is loaded. Each level visited takes a registered read through
//   the single read port of the node store.
//   The response sits in an output register; if out_tready is low the
//   sequencer holds in its final step until the register frees up.
//   Reset empties the set at once (root links are flip-flops); no clearing
//   pass is needed and the first request may follow straight away.
// ----------------------------------------------------------------------------
module binary_trie_max_xor
  import btmx_pkg::*;
#(
  parameter int NODES      = 4096,
  parameter int KEY_BITS   = 30,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [29:0] key_value, [31:30] zero
  input  logic [1:0]  in_tuser,   // [1:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [29:0] xor_result, [31:30] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int IW = $clog2(NODES);
  localparam int BW = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

  mem_we_t               we;
  logic [IW-1:0]         node_raddr, node_waddr, link_wdata, stk_raddr, stk_waddr;
  logic [IW-1:0]         idx_wdata, link0_q, link1_q, stk_q, path_q;
  logic [COUNT_BITS-1:0] count_wdata, count_q;
  logic [BW-1:0]         path_raddr, path_waddr;
  logic [KEY_BITS-1:0]   req_key, rsp_result;
  logic [KEY_BITS+FIELD_BITS-1:0] key_ext, res_ext;
  status_t               rsp_status;

  // keys wider than the field read as zero above it
  assign key_ext = {{KEY_BITS{1'b0}}, in_tdata[FIELD_BITS-1:0]};
  assign req_key = key_ext[KEY_BITS-1:0];
  assign res_ext = {{FIELD_BITS{1'b0}}, rsp_result};

  assign out_tdata = {2'b00, res_ext[FIELD_BITS-1:0]};
  assign out_tuser = rsp_status;

  btmx_ctrl #(
    .NODES(NODES), .KEY_BITS(KEY_BITS), .COUNT_BITS(COUNT_BITS)
  ) u_ctrl (
    .clk, .rst_n,
    .req_valid  (in_tvalid),
    .req_ready  (in_tready),
    .req_mode   (mode_t'(in_tuser)),
    .req_key    (req_key),
    .rsp_valid  (out_tvalid),
    .rsp_ready  (out_tready),
    .rsp_result (rsp_result),
    .rsp_status (rsp_status),
    .we, .node_raddr, .node_waddr, .link_wdata, .count_wdata,
    .stk_raddr, .stk_waddr, .path_raddr, .path_waddr, .idx_wdata,
    .link0_q, .link1_q, .count_q, .stk_q, .path_q
  );

  btmx_mem #(
    .NODES(NODES), .KEY_BITS(KEY_BITS), .COUNT_BITS(COUNT_BITS)
  ) u_mem (
    .clk, .rst_n,
    .we, .node_raddr, .node_waddr, .link_wdata, .count_wdata,
    .stk_raddr, .stk_waddr, .path_raddr, .path_waddr, .idx_wdata,
    .link0_q, .link1_q, .count_q, .stk_q, .path_q
  );

endmodule

// ----- dv/binary_trie_max_xor_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_trie_max_xor_checker: response predictor and scoreboard
// Mirrors the trie on every accepted request and checks each response in order.
// ----------------------------------------------------------------------------
module binary_trie_max_xor_checker
  import btmx_pkg::*;
#(
  parameter int NODES      = 4096,
  parameter int KEY_BITS   = 30,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [1:0]  out_tuser,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [29:0] xor_result;
    status_t     status;
  } reply_t;

  int unsigned trie_kid[NODES][2];
  longint unsigned trie_cnt[NODES];
  int unsigned fresh_node;
  int unsigned spare_nodes[$];
  reply_t      reply_q[$];

  function automatic int unsigned grab_node();
    int unsigned n;
    if (spare_nodes.size() > 0) n = spare_nodes.pop_back();
    else begin
      n = fresh_node;
      fresh_node++;
    end
    trie_kid[n][0] = 0;
    trie_kid[n][1] = 0;
    trie_cnt[n] = 0;
    return n;
  endfunction

  function automatic status_t add_key(logic [29:0] k);
    int unsigned cur;
    int lvl;
    cur = 0;
    lvl = KEY_BITS - 1;
    while (lvl >= 0 && trie_kid[cur][k[lvl]] != 0) begin
      cur = trie_kid[cur][k[lvl]];
      lvl--;
    end
    if (lvl + 1 > spare_nodes.size() + NODES - fresh_node) return STAT_FULL;
    if (lvl < 0 && trie_cnt[cur] >= (64'd1 << COUNT_BITS) - 1) return STAT_FULL;
    while (lvl >= 0) begin
      trie_kid[cur][k[lvl]] = grab_node();
      cur = trie_kid[cur][k[lvl]];
      lvl--;
    end
    trie_cnt[cur]++;
    return STAT_OK;
  endfunction

  function automatic status_t drop_key(logic [29:0] k);
    int unsigned trail[KEY_BITS];
    int unsigned cur;
    cur = 0;
    for (int d = 0; d < KEY_BITS; d++) begin
      if (trie_kid[cur][k[KEY_BITS-1-d]] == 0) return STAT_ABSENT;
      trail[d] = cur;
      cur = trie_kid[cur][k[KEY_BITS-1-d]];
    end
    if (trie_cnt[cur] == 0) return STAT_ABSENT;
    trie_cnt[cur]--;
    if (trie_cnt[cur] != 0) return STAT_OK;
    // prune up to the first node that still has a child
    for (int d = KEY_BITS - 1; d >= 0; d--) begin
      if (trie_kid[cur][0] != 0 || trie_kid[cur][1] != 0) break;
      if (spare_nodes.size() < NODES) spare_nodes.push_back(cur);
      trie_kid[trail[d]][k[KEY_BITS-1-d]] = 0;
      cur = trail[d];
    end
    return STAT_OK;
  endfunction

  function automatic logic [29:0] best_xor(logic [29:0] k);
    int unsigned cur;
    logic [29:0] acc;
    cur = 0;
    acc = '0;
    for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
      if (trie_kid[cur][!k[lvl]] != 0) begin
        acc[lvl] = 1'b1;
        cur = trie_kid[cur][!k[lvl]];
      end else if (trie_kid[cur][k[lvl]] != 0) cur = trie_kid[cur][k[lvl]];
      else break;
    end
    return acc;
  endfunction

  always @(posedge clk) begin
    reply_t want, got;
    if (!rst_n) begin
      fresh_node = 1;
      spare_nodes.delete();
      trie_kid[0][0] = 0;
      trie_kid[0][1] = 0;
      trie_cnt[0] = 0;
      reply_q.delete();
      fail_count <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.xor_result = out_tdata[29:0];
        got.status = status_t'(out_tuser);
        if (reply_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected response %h/%0d", got.xor_result, got.status);
        end else begin
          want = reply_q.pop_front();
          if (want !== got || out_tdata[31:30] !== 2'b00) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: expected xor %h status %0d, got data %h status %0d",
                       want.xor_result, want.status, out_tdata, out_tuser);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        want.xor_result = '0;
        want.status = STAT_OK;
        case (mode_t'(in_tuser))
          MODE_INSERT: want.status = add_key(in_tdata[29:0]);
          MODE_REMOVE: want.status = drop_key(in_tdata[29:0]);
          MODE_QUERY:  want.xor_result = best_xor(in_tdata[29:0]);
          default: ;
        endcase
        reply_q.push_back(want);
      end
    end
    pending <= reply_q.size();
  end

endmodule

// ----- dv/binary_trie_max_xor_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_trie_max_xor_test: stimulus and verdict for the trie max-xor block
// Directed corner requests, then random insert/remove/query traffic with
// bursty sending, random output stalls and a long hold-off.
// ----------------------------------------------------------------------------
module binary_trie_max_xor_test;
  import btmx_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  int          fail_count;
  int          pending;
  logic        hold_off;
  logic [29:0] key_pool[$];

  binary_trie_max_xor u_top (.*);

  binary_trie_max_xor_checker u_chk (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // receiver: random stall pattern, plus one long hold-off
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) out_tready <= 1'b0;
      else if ($urandom_range(0, 9) < 3) out_tready <= 1'($urandom_range(0, 1));
      else out_tready <= 1'b1;
    end
  end

  task automatic send(mode_t m, logic [29:0] k);
    in_tvalid = 1'b1;
    in_tuser  = m;
    in_tdata  = {2'b00, k};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  function automatic logic [29:0] rand_key();
    logic [29:0] k;
    k = 30'($urandom());
    // favour keys already stored so removes hit and paths share prefixes
    if (key_pool.size() > 0 && $urandom_range(0, 2) != 0) begin
      k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      if ($urandom_range(0, 3) == 0) k[$urandom_range(0, 29)] ^= 1'b1;
    end else if ($urandom_range(0, 1) == 0) k = k & 30'h3f;
    return k;
  endfunction

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    mode_t       m;
    logic [29:0] k;
    int          burst;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = MODE_INSERT;
    hold_off  = 1'b0;
    rst_n     = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed corners
    send(MODE_QUERY, 30'h0);
    send(MODE_QUERY, 30'h3fffffff);
    send(MODE_REMOVE, 30'h0);
    send(MODE_NONE, 30'h15555555);
    send(MODE_INSERT, 30'h0);
    send(MODE_QUERY, 30'h3fffffff);
    send(MODE_INSERT, 30'h3fffffff);
    send(MODE_INSERT, 30'h3fffffff);
    send(MODE_QUERY, 30'h0);
    send(MODE_QUERY, 30'h2aaaaaaa);
    send(MODE_REMOVE, 30'h3fffffff);
    send(MODE_QUERY, 30'h0);
    send(MODE_REMOVE, 30'h3fffffff);
    send(MODE_REMOVE, 30'h3fffffff);
    send(MODE_REMOVE, 30'h3ffffffe);
    send(MODE_QUERY, 30'h1);
    send(MODE_INSERT, 30'h2aaaaaaa);
    send(MODE_INSERT, 30'h15555555);
    send(MODE_QUERY, 30'h2aaaaaaa);
    send(MODE_REMOVE, 30'h0);
    send(MODE_REMOVE, 30'h2aaaaaaa);
    send(MODE_REMOVE, 30'h15555555);
    send(MODE_QUERY, 30'h12345678);

    // fill the pool with 200 random keys, so that inserts are refused once it is full
    for (int i = 0; i < 200; i++) begin
      k = 30'($urandom());
      key_pool.push_back(k);
      send(MODE_INSERT, k);
    end
    send(MODE_QUERY, 30'($urandom()));
    // free them again
    while (key_pool.size() > 0) send(MODE_REMOVE, key_pool.pop_back());

    // wait for every response, then a long stall with the sender pressing on
    while (pending != 0) @(negedge clk);
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 8; i++) send(MODE_QUERY, 30'($urandom()));
    join

    // several copies of one key
    for (int i = 0; i < 4; i++) send(MODE_INSERT, 30'h3);
    send(MODE_REMOVE, 30'h3);
    send(MODE_INSERT, 30'h3);
    send(MODE_INSERT, 30'h3);
    send(MODE_QUERY, 30'h3);

    for (int n = 0; n < 1100;) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst && n < 1100; b++, n++) begin
        k = rand_key();
        case ($urandom_range(0, 19))
          0:            m = MODE_NONE;
          1,2,3,4,5,6:  m = MODE_INSERT;
          7,8,9,10,11:  m = MODE_REMOVE;
          default:      m = MODE_QUERY;
        endcase
        if (m == MODE_INSERT && key_pool.size() < 300) key_pool.push_back(k);
        send(m, k);
      end
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end

    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- binary_trie_max_xor.f -----
src/btmx_pkg.sv
src/btmx_mem.sv
src/btmx_ctrl.sv
src/binary_trie_max_xor.sv
dv/binary_trie_max_xor_checker.sv
dv/binary_trie_max_xor_test.sv
